@@ design/blstk_pkg.sv @@
// ----------------------------------------------------------------------------
// blstk_pkg
// shared types, sizes and helpers of the bounded lifo stack with search
// ----------------------------------------------------------------------------
package blstk_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_BITS   = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int CAP_RESET   = 64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_SEARCH = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic                        full;
        logic                        empty;
        logic [CNT_W-1:0]            count;
        logic [ADDR_W-1:0]           index;
        logic signed [WORD_BITS-1:0] data;
        status_t                     status;
    } result_t;

    function automatic result_t make_result(
        input status_t                     sts,
        input logic signed [WORD_BITS-1:0] data,
        input logic [ADDR_W-1:0]           index,
        input logic [CNT_W-1:0]            count,
        input logic [CNT_W-1:0]            cap
    );
        result_t r;
        r.status = sts;
        r.data   = data;
        r.index  = index;
        r.count  = count;
        r.empty  = (count == '0);
        r.full   = (count >= cap);
        return r;
    endfunction

endpackage

@@ design/blstk_ram.sv @@
// ----------------------------------------------------------------------------
// blstk_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module blstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/bounded_lifo_stack_with_search.sv @@
// push, clear, unused codes, failed pop/peek/push and search on empty stack: result goes
// to the output register (hold register if busy); pop and peek: one registered ram read first
// search: one ram read per entry, top down, until a hit or the bottom entry is read;
//   one item is in work at a time
// output register frees the input side while a result waits for m_tready
// synchronous active-low reset clears count, capacity (to 64) and control; ram is not cleared
// ----------------------------------------------------------------------------
// bounded_lifo_stack_with_search
// lifo stack of signed words in a ram with push, pop, peek, clear and top-down search
// ----------------------------------------------------------------------------
module bounded_lifo_stack_with_search (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [blstk_pkg::CNT_W-1:0]     cfg_wr_data,  // capacity_limit
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [blstk_pkg::WORD_BITS-1:0] s_tdata,      // data_value
    input  logic [blstk_pkg::OP_W-1:0]      s_tuser,      // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // data_out[31:0], found_index[37:32], entry_count[44:38], is_empty[45],
    // is_full[46], zero[47]
    output logic [47:0]                     m_tdata,
    output logic [blstk_pkg::STATUS_W-1:0]  m_tuser       // status
);

    localparam int AW = blstk_pkg::ADDR_W;
    localparam int CW = blstk_pkg::CNT_W;
    localparam int WB = blstk_pkg::WORD_BITS;

    blstk_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      capacity_reg;
    logic [CW-1:0]      cap;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic signed [WB-1:0] key_reg, key_next;
    blstk_pkg::result_t res_c, hold_reg, out_reg;
    logic               m_tvalid_reg;
    logic               fin;
    logic               out_free;
    logic               s_acc;
    logic               wr_en;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [WB-1:0]      rd_data;
    blstk_pkg::op_t     op;

    assign cap      = (capacity_reg > CW'(blstk_pkg::STACK_DEPTH)) ?
                      CW'(blstk_pkg::STACK_DEPTH) : capacity_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == blstk_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign op       = blstk_pkg::op_t'(s_tuser);
    assign rd_addr  = (state_reg == blstk_pkg::ST_IDLE) ? AW'(count_reg - CW'(1))
                                                        : (ptr_reg - AW'(1));

    blstk_ram #(
        .WIDTH (WB),
        .DEPTH (blstk_pkg::STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // datapath and ram control
    always_comb begin
        fin        = 1'b0;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        key_next   = key_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        res_c      = blstk_pkg::make_result(blstk_pkg::STS_OK, '0, '0, count_reg, cap);
        case (state_reg)
            blstk_pkg::ST_IDLE: begin
                if (s_acc) begin
                    case (op)
                        blstk_pkg::OP_PUSH: begin
                            fin = 1'b1;
                            if (count_reg >= cap) begin
                                res_c = blstk_pkg::make_result(blstk_pkg::STS_FULL, '0, '0,
                                                               count_reg, cap);
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                res_c      = blstk_pkg::make_result(blstk_pkg::STS_OK, '0,
                                                                    '0, count_next, cap);
                            end
                        end
                        blstk_pkg::OP_POP: begin
                            if (count_reg == '0) begin
                                fin   = 1'b1;
                                res_c = blstk_pkg::make_result(blstk_pkg::STS_EMPTY, '0, '0,
                                                               count_reg, cap);
                            end else begin
                                rd_en      = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        blstk_pkg::OP_PEEK: begin
                            if (count_reg == '0) begin
                                fin   = 1'b1;
                                res_c = blstk_pkg::make_result(blstk_pkg::STS_EMPTY, '0, '0,
                                                               count_reg, cap);
                            end else begin
                                rd_en = 1'b1;
                            end
                        end
                        blstk_pkg::OP_CLEAR: begin
                            fin        = 1'b1;
                            count_next = '0;
                            res_c      = blstk_pkg::make_result(blstk_pkg::STS_OK, '0, '0,
                                                                '0, cap);
                        end
                        blstk_pkg::OP_SEARCH: begin
                            if (count_reg == '0) begin
                                fin   = 1'b1;
                                res_c = blstk_pkg::make_result(blstk_pkg::STS_NOT_FOUND, '0,
                                                               '0, count_reg, cap);
                            end else begin
                                rd_en    = 1'b1;
                                key_next = s_tdata;
                                ptr_next = AW'(count_reg - CW'(1));
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            blstk_pkg::ST_READ: begin
                fin   = 1'b1;
                res_c = blstk_pkg::make_result(blstk_pkg::STS_OK, rd_data, '0, count_reg, cap);
            end
            blstk_pkg::ST_SEARCH: begin
                if (rd_data == key_reg) begin
                    fin   = 1'b1;
                    res_c = blstk_pkg::make_result(blstk_pkg::STS_OK, '0, ptr_reg,
                                                   count_reg, cap);
                end else if (ptr_reg == '0) begin
                    fin   = 1'b1;
                    res_c = blstk_pkg::make_result(blstk_pkg::STS_NOT_FOUND, '0, '0,
                                                   count_reg, cap);
                end else begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_reg - AW'(1);
                end
            end
            blstk_pkg::ST_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            blstk_pkg::ST_IDLE: begin
                if (rd_en) begin
                    state_next = (op == blstk_pkg::OP_SEARCH) ? blstk_pkg::ST_SEARCH
                                                              : blstk_pkg::ST_READ;
                end else if (fin && !out_free) begin
                    state_next = blstk_pkg::ST_HOLD;
                end
            end
            blstk_pkg::ST_READ, blstk_pkg::ST_SEARCH: begin
                if (fin) begin
                    state_next = out_free ? blstk_pkg::ST_IDLE : blstk_pkg::ST_HOLD;
                end
            end
            blstk_pkg::ST_HOLD: begin
                if (out_free) begin
                    state_next = blstk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = blstk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= blstk_pkg::ST_IDLE;
            count_reg    <= '0;
            capacity_reg <= CW'(blstk_pkg::CAP_RESET);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if (fin && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (state_reg == blstk_pkg::ST_HOLD && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        key_reg <= key_next;
        if (fin && !out_free) begin
            hold_reg <= res_c;
        end
        if (fin && out_free) begin
            out_reg <= res_c;
        end else if (state_reg == blstk_pkg::ST_HOLD && out_free) begin
            out_reg <= hold_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.full, out_reg.empty, out_reg.count,
                       out_reg.index, out_reg.data};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(blstk_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_full_push_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && op == blstk_pkg::OP_PUSH && count_reg >= cap)
        |=> count_reg == $past(count_reg))
        else $error("push on full stack changed count");

    a_search_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == blstk_pkg::ST_SEARCH) |-> (CW'(ptr_reg) < count_reg))
        else $error("search pointer above top of stack");

    a_flags_match_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_reg.empty == (out_reg.count == '0)))
        else $error("empty flag disagrees with count");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && rd_en) |=> !s_tready)
        else $error("input taken while a ram read is in flight");

endmodule
